FILE: sv/dhte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_pkg
// Shared types and constants of the double hashing table engine.
// ----------------------------------------------------------------------------
package dhte_pkg;

  localparam int TABLE_SLOTS_DEF   = 1024;
  localparam int MAX_KEY_BYTES_DEF = 8;

  localparam int CFG_W   = 11;
  localparam int TOTAL_W = 11;
  localparam int LEN_W   = 4;
  localparam int HASH_W  = 32;
  localparam int VAL_W   = 32;
  localparam int KEYP_W  = 64;
  localparam int FUNC_W  = 2;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [CFG_W-1:0]  MOD_MIN   = 11'd13;
  localparam logic [CFG_W-1:0]  MOD_RESET = 11'd1021;

  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_DIV_M,
    S_DIV_S,
    S_RD,
    S_CHK,
    S_RES,
    S_DONE
  } state_t;

endpackage

FILE: sv/dhte_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dhte_divider
  import dhte_pkg::*;
#(
  parameter int DW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [DW-1:0]     divisor,
  output logic              done,
  output logic [DW-1:0]     remainder
);

  logic [HASH_W-1:0] shreg;
  logic [DW-1:0]     dreg;
  logic [DW-1:0]     rem;
  logic [4:0]        cnt;
  logic              busy;
  logic [DW:0]       trial;

  assign trial     = {rem, shreg[HASH_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= '0;
      shreg <= dividend;
      dreg  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= DW'(trial - {1'b0, dreg});
      end else begin
        rem <= trial[DW-1:0];
      end
      shreg <= {shreg[HASH_W-2:0], 1'b0};
      cnt   <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

FILE: sv/double_hash_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_engine
// Open addressing key/value table with FNV-1 hashing and double hashing.
// ----------------------------------------------------------------------------
//  channel  handshake              words
//  in       in_valid / in_stall    func, key_bytes, key_len, value
//  out      out_valid / out_stall  found, read_value, entry_total, status
//  cfg      cfg_wr_en              cfg_wr_data (table modulus)
//
// In a set or get the hash uses one multiply per key byte, the shared
// remainder unit works out each of the two modulos in turn, and each
// probe is a read and a check of slot RAM.
// Reset and a clear both sweep every slot of the mark RAM.
// A word is taken only when idle; a stalled result holds the next one back.
module double_hash_table_engine
  import dhte_pkg::*;
#(
  parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  func,
  input  logic [KEYP_W-1:0]  key_bytes,
  input  logic [LEN_W-1:0]   key_len,
  input  logic [VAL_W-1:0]   value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [VAL_W-1:0]   read_value,
  output logic [TOTAL_W-1:0] entry_total,
  output logic               status
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int MW = $clog2(TABLE_SLOTS + 1);
  localparam int EW = (MW > CFG_W) ? MW : CFG_W;
  localparam int KW = 8 * MAX_KEY_BYTES;
  localparam int RW = KW + LEN_W + HASH_W + VAL_W;

  state_t state, state_next;

  logic [CFG_W-1:0]  table_modulus;
  logic [MW-1:0]     live_count;
  logic [EW-1:0]     tm_x;
  logic [MW-1:0]     m_eff;

  logic [FUNC_W-1:0] func_q;
  logic [KW-1:0]     key_q;
  logic [KW-1:0]     key_sh;
  logic [LEN_W-1:0]  len_q;
  logic [VAL_W-1:0]  val_q;
  logic [HASH_W-1:0] hash_q;
  logic [LEN_W-1:0]  bcnt;
  logic [AW-1:0]     ccnt;
  logic              clr_op;

  logic [AW-1:0]     idx;
  logic [MW-1:0]     step;
  logic [MW-1:0]     ncnt;
  logic              hit_v;
  logic              tomb_v;
  logic              empty_v;
  logic [AW-1:0]     tomb_idx;
  logic [AW-1:0]     empty_idx;
  logic [VAL_W-1:0]  hit_val;

  mark_t             mark_mem [TABLE_SLOTS];
  logic [RW-1:0]     rec_mem  [TABLE_SLOTS];
  mark_t             mark_q;
  logic [RW-1:0]     rec_q;

  logic              mark_we;
  logic [AW-1:0]     mark_waddr;
  mark_t             mark_wdata;
  logic              rec_we;
  logic [AW-1:0]     dst;

  logic              res_found;
  logic [VAL_W-1:0]  res_val;
  logic              res_status;

  logic              div_start;
  logic              div_done;
  logic [MW-1:0]     div_divisor;
  logic [MW-1:0]     div_rem;

  logic [KW-1:0]     key_in;
  logic [LEN_W-1:0]  len_in;
  logic              accept;
  logic              hash_fin;
  logic              probe_match;
  logic              chk_stop;
  logic [MW:0]       idx_sum;
  logic [AW-1:0]     idx_adv;
  logic              is_set;
  logic              ins_ok;
  logic              out_free;

  assign tm_x = EW'(table_modulus);
  always_comb begin
    if (tm_x < EW'(MOD_MIN)) begin
      m_eff = MW'(MOD_MIN);
    end else if (tm_x > EW'(TABLE_SLOTS)) begin
      m_eff = MW'(TABLE_SLOTS);
    end else begin
      m_eff = MW'(tm_x);
    end
  end

  always_comb begin
    len_in = (key_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_len;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      key_in[8*i +: 8] = (LEN_W'(i) < len_in) ? key_bytes[8*i +: 8] : 8'h00;
    end
  end

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state != S_IDLE);
  assign hash_fin    = (bcnt == len_q);
  assign probe_match = (rec_q[RW-1 -: KW] == key_q)
                    && (rec_q[VAL_W+HASH_W +: LEN_W] == len_q)
                    && (rec_q[VAL_W +: HASH_W] == hash_q);
  assign chk_stop    = (mark_q == MARK_EMPTY)
                    || ((mark_q == MARK_LIVE) && probe_match)
                    || (ncnt == m_eff - MW'(1));
  assign idx_sum     = {1'b0, MW'(idx)} + {1'b0, step};
  assign idx_adv     = (idx_sum >= {1'b0, m_eff}) ? AW'(idx_sum - {1'b0, m_eff})
                                                  : AW'(idx_sum);
  assign is_set      = (func_q == FUNC_SET);
  assign ins_ok      = is_set && (val_q != '0) && !hit_v && (tomb_v || empty_v);
  assign dst         = tomb_v ? tomb_idx : empty_idx;
  assign out_free    = !out_valid || !out_stall;
  assign div_divisor = (state == S_HASH) ? m_eff : m_eff - MW'(2);

  dhte_divider #(
    .DW(MW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (hash_q),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (ccnt == AW'(TABLE_SLOTS - 1)) begin
          state_next = clr_op ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_SET || func == FUNC_GET) begin
            state_next = S_HASH;
          end else if (func == FUNC_CLEAR) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_HASH:  if (hash_fin) state_next = S_DIV_M;
      S_DIV_M: if (div_done) state_next = S_DIV_S;
      S_DIV_S: if (div_done) state_next = S_RD;
      S_RD:    state_next = S_CHK;
      S_CHK:   state_next = chk_stop ? S_RES : S_RD;
      S_RES:   state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    mark_we    = 1'b0;
    mark_waddr = ccnt;
    mark_wdata = MARK_EMPTY;
    rec_we     = 1'b0;
    unique case (state)
      S_CLEAR: mark_we = 1'b1;
      S_HASH:  div_start = hash_fin;
      S_DIV_M: div_start = div_done;
      S_RES: begin
        if (is_set && hit_v && (val_q == '0)) begin
          mark_we    = 1'b1;
          mark_waddr = idx;
          mark_wdata = MARK_TOMB;
        end else if (is_set && hit_v) begin
          rec_we     = 1'b1;
        end else if (ins_ok) begin
          mark_we    = 1'b1;
          mark_waddr = dst;
          mark_wdata = MARK_LIVE;
          rec_we     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (rec_we) begin
      rec_mem[hit_v ? idx : dst] <= {key_q, len_q, hash_q, val_q};
    end
    mark_q <= mark_mem[idx];
    rec_q  <= rec_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      table_modulus <= MOD_RESET;
      live_count    <= '0;
      ccnt          <= '0;
      clr_op        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        table_modulus <= cfg_wr_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          ccnt <= ccnt + AW'(1);
          if (ccnt == AW'(TABLE_SLOTS - 1)) begin
            live_count <= '0;
          end
        end
        S_IDLE: begin
          ccnt       <= '0;
          func_q     <= func;
          key_q      <= key_in;
          key_sh     <= key_in;
          len_q      <= len_in;
          val_q      <= value;
          hash_q     <= FNV_BASIS;
          bcnt       <= '0;
          clr_op     <= 1'b1;
          res_found  <= 1'b0;
          res_val    <= '0;
          res_status <= 1'b0;
        end
        S_HASH: begin
          if (!hash_fin) begin
            hash_q <= (hash_q * FNV_PRIME) ^ HASH_W'(key_sh[7:0]);
            key_sh <= key_sh >> 8;
            bcnt   <= bcnt + LEN_W'(1);
          end
        end
        S_DIV_M: begin
          if (div_done) begin
            idx <= AW'(div_rem);
          end
        end
        S_DIV_S: begin
          step    <= div_rem + MW'(1);
          ncnt    <= '0;
          hit_v   <= 1'b0;
          tomb_v  <= 1'b0;
          empty_v <= 1'b0;
        end
        S_CHK: begin
          if (mark_q == MARK_EMPTY) begin
            empty_v   <= 1'b1;
            empty_idx <= idx;
          end else if (mark_q == MARK_LIVE && probe_match) begin
            hit_v   <= 1'b1;
            hit_val <= rec_q[VAL_W-1:0];
          end else begin
            if (mark_q == MARK_TOMB && !tomb_v) begin
              tomb_v   <= 1'b1;
              tomb_idx <= idx;
            end
            if (!chk_stop) begin
              ncnt <= ncnt + MW'(1);
              idx  <= idx_adv;
            end
          end
        end
        S_RES: begin
          res_found <= hit_v;
          if (func_q == FUNC_GET && hit_v) begin
            res_val <= hit_val;
          end
          if (is_set && hit_v && (val_q == '0)) begin
            live_count <= live_count - MW'(1);
          end else if (ins_ok) begin
            live_count <= live_count + MW'(1);
          end else if (is_set && !hit_v && (val_q != '0)) begin
            res_status <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            found       <= res_found;
            read_value  <= res_val;
            entry_total <= TOTAL_W'(live_count);
            status      <= res_status;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= MW'(TABLE_SLOTS))
    else $error("live entry count exceeds the table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("engine stayed idle after taking a word");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> ($past(state) == S_RD))
    else $error("slot check without a preceding read");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(status && found))
    else $error("full status reported for a key that was found");
`endif

endmodule
